@@ src/hcbp_pkg.sv @@
// Shared constants and types of the Huffman code bit packer.
package hcbp_pkg;

	localparam int CODE_BITS = 32;
	localparam int LEN_BITS  = 6;
	localparam int OUT_BITS  = 32;
	localparam int FUNC_BITS = 2;
	localparam int SYM_BITS  = 8;

	localparam logic [FUNC_BITS-1:0] FUNC_LOAD   = 2'd0;
	localparam logic [FUNC_BITS-1:0] FUNC_ENCODE = 2'd1;
	localparam logic [FUNC_BITS-1:0] FUNC_FLUSH  = 2'd2;

	typedef struct packed {
		logic                 valid;
		logic [FUNC_BITS-1:0] func;
		logic                 in_range;
	} hcbp_req_t;

endpackage

@@ src/hcbp_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
module hcbp_ram
	#(
		parameter int WIDTH = 38,
		parameter int DEPTH = 256
	)
	(
		input  logic                     clk,
		input  logic                     we,
		input  logic [$clog2(DEPTH)-1:0] waddr,
		input  logic [WIDTH-1:0]         wdata,
		input  logic                     re,
		input  logic [$clog2(DEPTH)-1:0] raddr,
		output logic [WIDTH-1:0]         rdata
	);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ src/hcbp_packer.sv @@
// Accumulator, shift-merge of looked-up codes and the output word register.
module hcbp_packer
	import hcbp_pkg::*;
	#(
		parameter int WORD_BITS = 32
	)
	(
		input  logic                 clk,
		input  logic                 arst_n,
		input  hcbp_req_t            req,
		input  logic [CODE_BITS-1:0] code,
		input  logic [LEN_BITS-1:0]  len,
		output logic                 take,
		output logic                 word_valid,
		input  logic                 word_stall,
		output logic [OUT_BITS-1:0]  packed_word,
		output logic                 is_flush
	);

	localparam int FW = $clog2(WORD_BITS);
	localparam int CW = WORD_BITS + CODE_BITS;
	localparam int TW = $clog2(WORD_BITS + CODE_BITS);

	logic [WORD_BITS-1:0] acc_q;
	logic [FW-1:0]        fill_q;
	logic                 out_valid_q;
	logic [OUT_BITS-1:0]  word_q;
	logic                 flush_q;

	logic [CODE_BITS-1:0] code_masked;
	logic [CW-1:0]        cat;
	logic [TW-1:0]        total;
	logic [TW-1:0]        over;
	logic                 full;
	logic [WORD_BITS-1:0] full_word;
	logic [WORD_BITS-1:0] flush_word;
	logic                 fire;
	logic                 is_encode;
	logic                 is_flush_op;

	assign take        = !out_valid_q || !word_stall;
	assign fire        = req.valid && take;
	assign is_encode   = (req.func == FUNC_ENCODE) && req.in_range;
	assign is_flush_op = (req.func == FUNC_FLUSH);

	assign code_masked = code & ~({CODE_BITS{1'b1}} << len);
	assign cat         = (CW'(acc_q) << len) | CW'(code_masked);
	assign total       = TW'(fill_q) + TW'(len);
	assign full        = (total >= TW'(WORD_BITS));
	assign over        = total - TW'(WORD_BITS);
	assign full_word   = WORD_BITS'(cat >> over);
	assign flush_word  = acc_q << (TW'(WORD_BITS) - TW'(fill_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else if (take) begin
			if (fire && is_encode) begin
				if (full) begin
					acc_q       <= WORD_BITS'(cat) & ~({WORD_BITS{1'b1}} << over);
					fill_q      <= FW'(over);
					out_valid_q <= 1'b1;
				end else begin
					acc_q       <= WORD_BITS'(cat);
					fill_q      <= FW'(total);
					out_valid_q <= 1'b0;
				end
			end else if (fire && is_flush_op && (fill_q != '0)) begin
				acc_q       <= '0;
				fill_q      <= '0;
				out_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && is_encode && full) begin
			word_q  <= OUT_BITS'(full_word);
			flush_q <= 1'b0;
		end else if (fire && is_flush_op && (fill_q != '0)) begin
			word_q  <= OUT_BITS'(flush_word);
			flush_q <= 1'b1;
		end
	end

	assign word_valid  = out_valid_q;
	assign packed_word = word_q;
	assign is_flush    = flush_q;

endmodule

@@ src/huffman_code_bit_packer.sv @@
// Top level of the Huffman code bit packer: table memory, lookup stage and packer.
//
// One transaction is taken every clock cycle, loads, encodes and flushes alike,
// as long as the word output is not held. A load writes the code table in the
// cycle it is accepted; an encode reads the table into the registered read
// port and the request register, and is merged into the accumulator when the
// packer takes it, so a packed word reaches the output word register after the
// table read and the shift-merge with the accumulator. The table has no reset
// and must be loaded before a symbol is encoded.
module huffman_code_bit_packer
	import hcbp_pkg::*;
	#(
		parameter int SYMBOL_COUNT = 256,
		parameter int WORD_BITS    = 32
	)
	(
		input  logic                 clk,
		input  logic                 arst_n,
		input  logic                 sym_valid,
		output logic                 sym_stall,
		input  logic [FUNC_BITS-1:0] func,
		input  logic [SYM_BITS-1:0]  symbol,
		input  logic [CODE_BITS-1:0] code_bits,
		input  logic [LEN_BITS-1:0]  code_length,
		output logic                 word_valid,
		input  logic                 word_stall,
		output logic [OUT_BITS-1:0]  packed_word,
		output logic                 is_flush
	);

	localparam int AW      = $clog2(SYMBOL_COUNT);
	localparam int MAX_LEN = (WORD_BITS < CODE_BITS) ? WORD_BITS : CODE_BITS;
	localparam int EW      = CODE_BITS + LEN_BITS;

	logic                 accept;
	logic                 in_range;
	logic [LEN_BITS-1:0]  len_sat;
	logic                 we;
	logic                 re;
	logic [EW-1:0]        rdata;
	logic                 take;
	hcbp_req_t            req_s1;

	assign sym_stall = req_s1.valid && !take;
	assign accept    = sym_valid && !sym_stall;
	assign in_range  = ({1'b0, symbol} < (SYM_BITS + 1)'(SYMBOL_COUNT));
	assign len_sat   = (code_length > LEN_BITS'(MAX_LEN)) ? LEN_BITS'(MAX_LEN) : code_length;
	assign we        = accept && (func == FUNC_LOAD) && in_range;
	assign re        = accept && (func == FUNC_ENCODE) && in_range;

	hcbp_ram #(
		.WIDTH(EW),
		.DEPTH(SYMBOL_COUNT)
	) u_table (
		.clk  (clk),
		.we   (we),
		.waddr(symbol[AW-1:0]),
		.wdata({len_sat, code_bits}),
		.re   (re),
		.raddr(symbol[AW-1:0]),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_s1 <= '0;
		end else if (accept) begin
			req_s1.valid    <= 1'b1;
			req_s1.func     <= func;
			req_s1.in_range <= in_range;
		end else if (take) begin
			req_s1.valid <= 1'b0;
		end
	end

	hcbp_packer #(
		.WORD_BITS(WORD_BITS)
	) u_packer (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req_s1),
		.code       (rdata[CODE_BITS-1:0]),
		.len        (rdata[EW-1:CODE_BITS]),
		.take       (take),
		.word_valid (word_valid),
		.word_stall (word_stall),
		.packed_word(packed_word),
		.is_flush   (is_flush)
	);

endmodule

@@ tb/hcbp_word_checker.sv @@
// Checker for the Huffman code bit packer: predicts packed words and compares them with the output.
module hcbp_word_checker
	import hcbp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 sym_valid,
	input  logic                 sym_stall,
	input  logic [FUNC_BITS-1:0] func,
	input  logic [SYM_BITS-1:0]  symbol,
	input  logic [CODE_BITS-1:0] code_bits,
	input  logic [LEN_BITS-1:0]  code_length,
	input  logic                 word_valid,
	input  logic                 word_stall,
	input  logic [OUT_BITS-1:0]  packed_word,
	input  logic                 is_flush,
	output int                   mismatches,
	output int                   words_due
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [OUT_BITS-1:0] word;
		logic                flush;
	} packed_result_t;

	logic [CODE_BITS-1:0] code_store [256];
	logic [LEN_BITS-1:0]  length_store [256];
	logic [63:0]          pending_bits = '0;
	int                   pending_count = 0;
	packed_result_t       words_expected [$];
	packed_result_t       due;
	int                   fault_total = 0;
	int                   left_count = 0;

	assign mismatches = fault_total;
	assign words_due  = left_count;

	function automatic bit pack_transaction(input logic [FUNC_BITS-1:0] op,
			input logic [SYM_BITS-1:0] sym, input logic [CODE_BITS-1:0] code_in,
			input logic [LEN_BITS-1:0] len_in, output packed_result_t word_out);
		int          len;
		int          total;
		int          over;
		logic [63:0] code;
		logic [63:0] joined;
		word_out = '0;
		case (op)
			FUNC_LOAD: begin
				code_store[sym] = code_in;
				length_store[sym] = (len_in > CODE_BITS) ? LEN_BITS'(CODE_BITS) : len_in;
				return 1'b0;
			end
			FUNC_ENCODE: begin
				len = int'(length_store[sym]);
				if (len == 0)
					return 1'b0;
				code = {32'b0, code_store[sym]} & ((64'd1 << len) - 64'd1);
				total = pending_count + len;
				if (total < OUT_BITS) begin
					pending_bits = (pending_bits << len) | code;
					pending_count = total;
					return 1'b0;
				end
				over = total - OUT_BITS;
				joined = (pending_bits << (OUT_BITS - pending_count)) | (code >> over);
				word_out.word = joined[OUT_BITS-1:0];
				word_out.flush = 1'b0;
				pending_bits = code & ((64'd1 << over) - 64'd1);
				pending_count = over;
				return 1'b1;
			end
			FUNC_FLUSH: begin
				if (pending_count == 0)
					return 1'b0;
				joined = pending_bits << (OUT_BITS - pending_count);
				word_out.word = joined[OUT_BITS-1:0];
				word_out.flush = 1'b1;
				pending_bits = '0;
				pending_count = 0;
				return 1'b1;
			end
			default: begin
				return 1'b0;
			end
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_bits = '0;
			pending_count = 0;
			words_expected.delete();
		end else begin
			if (sym_valid && !sym_stall) begin
				if (pack_transaction(func, symbol, code_bits, code_length, due))
					words_expected.push_back(due);
			end
			if (word_valid && !word_stall) begin
				if (words_expected.size() == 0) begin
					fault_total++;
					$display("%0t: unexpected word, expected none, actual %h flush %b",
						$time, packed_word, is_flush);
				end else begin
					due = words_expected.pop_front();
					if (packed_word !== due.word) begin
						fault_total++;
						$display("%0t: packed_word mismatch, expected %h, actual %h",
							$time, due.word, packed_word);
					end
					if (is_flush !== due.flush) begin
						fault_total++;
						$display("%0t: is_flush mismatch, expected %b, actual %b",
							$time, due.flush, is_flush);
					end
				end
			end
		end
		left_count = words_expected.size();
	end

endmodule

@@ tb/tb_top.sv @@
// Testbench top for the Huffman code bit packer: clock, reset, stimulus and verdict.
module tb_top
	import hcbp_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [FUNC_BITS-1:0] FUNC_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS   = 1200;
	localparam int QUIET_FROM     = 1050;
	localparam int PRESSURE_AT    = 400;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 4000;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 sym_valid = 1'b0;
	logic                 sym_stall;
	logic [FUNC_BITS-1:0] func = FUNC_LOAD;
	logic [SYM_BITS-1:0]  symbol = '0;
	logic [CODE_BITS-1:0] code_bits = '0;
	logic [LEN_BITS-1:0]  code_length = '0;
	logic                 word_valid;
	logic                 word_stall = 1'b0;
	logic [OUT_BITS-1:0]  packed_word;
	logic                 is_flush;
	int                   mismatches;
	int                   words_due;

	bit                   quiet = 1'b0;
	bit                   want_hold = 1'b0;
	bit                   loaded [256];
	logic [SYM_BITS-1:0]  known_syms [$];

	huffman_code_bit_packer DUT (.*);

	hcbp_word_checker word_check (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic offer_item(input logic [FUNC_BITS-1:0] f, input logic [SYM_BITS-1:0] s,
			input logic [CODE_BITS-1:0] c, input logic [LEN_BITS-1:0] l);
		int gap;
		@(negedge clk);
		func = f;
		symbol = s;
		code_bits = c;
		code_length = l;
		sym_valid = 1'b1;
		@(posedge clk);
		while (sym_stall)
			@(posedge clk);
		if (!quiet && $urandom_range(0, 9) == 0) begin
			gap = $urandom_range(1, 17);
			@(negedge clk);
			sym_valid = 1'b0;
			repeat (gap - 1)
				@(negedge clk);
		end
	endtask

	task automatic load_entry(input logic [SYM_BITS-1:0] s, input logic [CODE_BITS-1:0] c,
			input logic [LEN_BITS-1:0] l);
		offer_item(FUNC_LOAD, s, c, l);
		if (!loaded[s]) begin
			loaded[s] = 1'b1;
			known_syms.push_back(s);
		end
	endtask

	initial begin
		forever begin
			@(negedge clk);
			if (want_hold) begin
				want_hold = 1'b0;
				word_stall = 1'b1;
				repeat (HOLD_CYCLES)
					@(negedge clk);
				word_stall = 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				word_stall = 1'b1;
				repeat ($urandom_range(1, 17))
					@(negedge clk);
				word_stall = 1'b0;
			end
		end
	end

	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((sym_valid && !sym_stall) || (word_valid && !word_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		int                  pick;
		logic [LEN_BITS-1:0] len;
		repeat (8)
			@(negedge clk);
		arst_n = 1'b1;

		load_entry(8'd0, 32'hFFFF_FFFF, 6'd32);
		load_entry(8'd255, 32'h0000_0000, 6'd1);
		load_entry(8'd1, 32'hA5A5_A5A5, 6'd5);
		load_entry(8'd2, 32'hFFFF_FFFF, 6'd0);
		load_entry(8'd3, 32'h8000_0001, 6'd63);
		load_entry(8'd4, 32'h1234_5678, 6'd33);
		offer_item(FUNC_FLUSH, 8'd0, 32'h0, 6'd0);
		offer_item(FUNC_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
		offer_item(FUNC_ENCODE, 8'd2, 32'h0, 6'd0);
		offer_item(FUNC_ENCODE, 8'd1, 32'h0, 6'd0);
		offer_item(FUNC_ENCODE, 8'd0, 32'h0, 6'd0);
		offer_item(FUNC_ENCODE, 8'd255, 32'h0, 6'd0);
		offer_item(FUNC_FLUSH, 8'd0, 32'h0, 6'd0);
		offer_item(FUNC_ENCODE, 8'd0, 32'h0, 6'd0);
		offer_item(FUNC_ENCODE, 8'd3, 32'h0, 6'd0);
		offer_item(FUNC_ENCODE, 8'd4, 32'h0, 6'd0);
		offer_item(FUNC_ENCODE, 8'd1, 32'h0, 6'd0);
		offer_item(FUNC_FLUSH, 8'd0, 32'h0, 6'd0);
		offer_item(FUNC_ENCODE, 8'd255, 32'h0, 6'd0);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			quiet = (n >= QUIET_FROM);
			if (n == PRESSURE_AT) begin
				quiet = 1'b1;
				want_hold = 1'b1;
				load_entry(8'd0, $urandom, 6'd32);
				repeat (40)
					offer_item(FUNC_ENCODE, 8'd0, $urandom, LEN_BITS'($urandom));
				quiet = 1'b0;
			end
			pick = $urandom_range(0, 99);
			if (pick < 10) begin
				case ($urandom_range(0, 19))
					0:                   len = 6'd0;
					14, 15, 16, 17:      len = LEN_BITS'($urandom_range(13, 32));
					18, 19:              len = LEN_BITS'($urandom_range(33, 63));
					default:             len = LEN_BITS'($urandom_range(1, 12));
				endcase
				load_entry(SYM_BITS'($urandom), $urandom, len);
			end else if (pick < 88) begin
				offer_item(FUNC_ENCODE, known_syms[$urandom_range(0, known_syms.size() - 1)],
					$urandom, LEN_BITS'($urandom));
			end else if (pick < 95) begin
				offer_item(FUNC_FLUSH, SYM_BITS'($urandom), $urandom, LEN_BITS'($urandom));
			end else begin
				offer_item(FUNC_UNUSED, SYM_BITS'($urandom), $urandom, LEN_BITS'($urandom));
			end
		end
		offer_item(FUNC_FLUSH, 8'd0, 32'h0, 6'd0);

		@(negedge clk);
		sym_valid = 1'b0;
		while (words_due != 0)
			@(posedge clk);
		repeat (8)
			@(posedge clk);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
